FILE: rtl/teq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types and constants of the timed event queue.
// ----------------------------------------------------------------------------
package teq_pkg;

	localparam int EVENT_SLOTS     = 16;
	localparam int HANDLER_ID_BITS = 8;
	localparam int SLOT_BITS       = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
	localparam int STEP_BITS       = $clog2(EVENT_SLOTS + 1);

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;
	localparam logic [1:0] MODE_CLEAR  = 2'd3;

	typedef logic [SLOT_BITS-1:0]       slot_idx_t;
	typedef logic [HANDLER_ID_BITS-1:0] handler_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item, start walk at head
		logic step;      // advance walk to next entry
		logic do_insert; // link new event at walk position
		logic do_remove; // unlink current entry
		logic do_clear;  // empty the pool
		logic set_found;
		logic set_full;
		logic head_load; // copy head entry to output registers
	} teq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pool_full;
		logic cur_valid;  // walk still on a list entry
		logic walk_done;  // step bound reached
		logic add_stop;   // new time is below current entry
		logic hit;        // current entry handler matches
	} teq_sts_t;

endpackage

FILE: rtl/timed_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_event_queue
// Time-ordered event pool with add, cancel, query and clear operations.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// in      | in_valid / in_ready  | mode current_cycle delay handler_id user_tag
// out     | out_valid / out_ready| found full_error scheduled_time head_*
//
// After the input transfer the sequencer walks the list, loads the head
// registers and then offers the result; the walk reads one slot per cycle
// and steps past at most sixteen entries. The next input transfer can come
// in the cycle after the result leaves.
// Reset empties the pool at once; no clearing pass.
// A stalled result holds; the next transfer is taken after it leaves.
// ----------------------------------------------------------------------------
module timed_event_queue
	import teq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] current_cycle,
	input  logic [31:0] delay,
	input  logic [7:0]  handler_id,
	input  logic [31:0] user_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic        full_error,
	output logic [63:0] scheduled_time,
	output logic        head_valid,
	output logic [63:0] head_time,
	output logic [7:0]  head_handler,
	output logic [31:0] head_tag
);

	teq_cmd_t cmd;
	teq_sts_t sts;

	teq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .mode,
		.out_valid, .out_ready, .cmd, .sts
	);

	teq_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .current_cycle, .delay, .handler_id,
		.user_tag, .found, .full_error, .scheduled_time, .head_valid,
		.head_time, .head_handler, .head_tag
	);

endmodule

FILE: rtl/teq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_ctrl
// Operation sequencer: walks the list one entry per cycle.
// ----------------------------------------------------------------------------
module teq_ctrl
	import teq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	output logic       out_valid,
	input  logic       out_ready,
	output teq_cmd_t   cmd,
	input  teq_sts_t   sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_HEAD = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0] state_q;
	logic [1:0] mode_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_WALK: begin
				case (mode_q)
					MODE_ADD: begin
						if (sts.pool_full)
							cmd.set_full = 1'b1;
						else if (!sts.cur_valid || sts.walk_done || sts.add_stop)
							cmd.do_insert = 1'b1;
						else
							cmd.step = 1'b1;
					end
					MODE_CANCEL, MODE_QUERY: begin
						if (sts.cur_valid && !sts.walk_done) begin
							if (sts.hit) begin
								cmd.set_found = 1'b1;
								cmd.do_remove = (mode_q == MODE_CANCEL);
							end else begin
								cmd.step = 1'b1;
							end
						end
					end
					default: cmd.do_clear = 1'b1;
				endcase
			end
			ST_HEAD: cmd.head_load = 1'b1;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_ADD;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_WALK;
					mode_q  <= mode;
				end
				ST_WALK: if (!cmd.step) state_q <= ST_HEAD;
				ST_HEAD: state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/teq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_dp
// Slot storage, list walk registers and result registers.
// ----------------------------------------------------------------------------
module teq_dp
	import teq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  teq_cmd_t    cmd,
	output teq_sts_t    sts,
	input  logic [63:0] current_cycle,
	input  logic [31:0] delay,
	input  logic [7:0]  handler_id,
	input  logic [31:0] user_tag,
	output logic        found,
	output logic        full_error,
	output logic [63:0] scheduled_time,
	output logic        head_valid,
	output logic [63:0] head_time,
	output logic [7:0]  head_handler,
	output logic [31:0] head_tag
);

	logic [EVENT_SLOTS-1:0] used_q;
	logic [63:0]            due_q  [EVENT_SLOTS];
	handler_t               hnd_q  [EVENT_SLOTS];
	logic [31:0]            tag_q  [EVENT_SLOTS];
	slot_idx_t              link_q [EVENT_SLOTS];
	logic [EVENT_SLOTS-1:0] has_link_q;
	slot_idx_t              first_q;
	logic                   nonempty_q;

	logic [63:0]    t_q;
	handler_t       h_q;
	logic [31:0]    utag_q;
	slot_idx_t      cur_q, prev_q;
	logic           cur_valid_q, prev_valid_q;
	logic [STEP_BITS-1:0] steps_q;

	// lowest free slot
	slot_idx_t free_idx;
	logic      have_free;
	always_comb begin
		free_idx  = '0;
		have_free = 1'b0;
		for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx  = SLOT_BITS'(i);
				have_free = 1'b1;
			end
		end
	end

	logic [63:0] cur_due;
	assign cur_due = due_q[cur_q];

	assign sts.pool_full = !have_free;
	assign sts.cur_valid = cur_valid_q;
	assign sts.walk_done = (steps_q == STEP_BITS'(EVENT_SLOTS));
	assign sts.add_stop  = (t_q < cur_due);
	assign sts.hit       = (hnd_q[cur_q] == h_q);

	// walk and operand registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q  <= 1'b0;
			prev_valid_q <= 1'b0;
			steps_q      <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
		end else if (cmd.load) begin
			cur_q        <= first_q;
			cur_valid_q  <= nonempty_q;
			prev_valid_q <= 1'b0;
			steps_q      <= '0;
		end else if (cmd.step) begin
			prev_q       <= cur_q;
			prev_valid_q <= 1'b1;
			cur_q        <= link_q[cur_q];
			cur_valid_q  <= has_link_q[cur_q];
			steps_q      <= steps_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q    <= current_cycle + {32'd0, delay};
			h_q    <= handler_id[HANDLER_ID_BITS-1:0];
			utag_q <= user_tag;
		end else if (cmd.step && t_q == cur_due) begin
			t_q <= t_q + 64'd1;
		end
	end

	// slot payload storage
	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			due_q[free_idx]  <= t_q;
			hnd_q[free_idx]  <= h_q;
			tag_q[free_idx]  <= utag_q;
			link_q[free_idx] <= cur_q;
			if (prev_valid_q) link_q[prev_q] <= free_idx;
		end else if (cmd.do_remove && prev_valid_q) begin
			link_q[prev_q] <= link_q[cur_q];
		end
	end

	// list control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			has_link_q <= '0;
			first_q    <= '0;
			nonempty_q <= 1'b0;
		end else if (cmd.do_clear) begin
			used_q     <= '0;
			first_q    <= '0;
			nonempty_q <= 1'b0;
		end else if (cmd.do_insert) begin
			used_q[free_idx]     <= 1'b1;
			has_link_q[free_idx] <= cur_valid_q;
			if (prev_valid_q) begin
				has_link_q[prev_q] <= 1'b1;
			end else begin
				first_q    <= free_idx;
				nonempty_q <= 1'b1;
			end
		end else if (cmd.do_remove) begin
			used_q[cur_q] <= 1'b0;
			if (prev_valid_q) begin
				has_link_q[prev_q] <= has_link_q[cur_q];
			end else begin
				first_q    <= link_q[cur_q];
				nonempty_q <= has_link_q[cur_q];
			end
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found          <= 1'b0;
			full_error     <= 1'b0;
			scheduled_time <= '0;
		end else if (cmd.load) begin
			found          <= 1'b0;
			full_error     <= 1'b0;
			scheduled_time <= '0;
		end else begin
			if (cmd.set_found) found <= 1'b1;
			if (cmd.set_full) full_error <= 1'b1;
			if (cmd.do_insert) scheduled_time <= t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid   <= 1'b0;
			head_time    <= '0;
			head_handler <= '0;
			head_tag     <= '0;
		end else if (cmd.head_load) begin
			head_valid <= nonempty_q;
			if (nonempty_q) begin
				head_time    <= due_q[first_q];
				head_handler <= 8'(hnd_q[first_q]);
				head_tag     <= tag_q[first_q];
			end else begin
				head_time    <= '0;
				head_handler <= '0;
				head_tag     <= '0;
			end
		end
	end

endmodule

FILE: rtl/teq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_checker
// Port-level checks of the timed event queue.
// ----------------------------------------------------------------------------
module teq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic        full_error,
	input logic [63:0] scheduled_time,
	input logic        head_valid
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found)
		&& $stable(scheduled_time))
		else $error("result changed under stall");

	// one item in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while result pending");

	// full error only with nonempty queue and no time
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_error |-> head_valid && !found && scheduled_time == 64'd0)
		else $error("bad full error result");

	// transfer in gives no result next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");

endmodule

bind timed_event_queue teq_checker u_teq_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.found, .full_error, .scheduled_time, .head_valid
);
